// File: src/indexed_deque_buffer_assert.svh
// ----------------------------------------------------------------------------
// Indexed deque buffer assertion macros
// Concurrent assertion shorthands used by the buffer controller.
// ----------------------------------------------------------------------------
`ifndef INDEXED_DEQUE_BUFFER_ASSERT_SVH
`define INDEXED_DEQUE_BUFFER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset
`define IDB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define IDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define IDB_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define IDB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// File: src/idb_pkg.sv
// ----------------------------------------------------------------------------
// Indexed deque buffer package
// Request and response types, command and status codes, default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package idb_pkg;

   // Default sizing
   localparam int DEPTH_DEF      = 1024;
   localparam int DATA_WIDTH_DEF = 32;

   // Fixed field widths
   localparam int CMD_W  = 3;
   localparam int POS_W  = 12;
   localparam int ITEM_W = 32;
   localparam int OCC_W  = 11;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_READ       = 3'd4,
      CMD_WRITE      = 3'd5
   } cmd_type;

   // Status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_RANGE = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   // Request payload
   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [POS_W-1:0]  position;
      logic [ITEM_W-1:0] item;
   } req_type;

   // Response payload
   typedef struct packed {
      logic [ITEM_W-1:0] item_out;
      status_type        status;
      logic [OCC_W-1:0]  occupancy;
   } rsp_type;

   // Response control carried from the controller to the output stage
   typedef struct packed {
      logic             valid;
      logic             use_data;
      status_type       status;
      logic [OCC_W-1:0] occupancy;
   } rsp_ctl_type;

endpackage

`default_nettype wire

// File: src/idb_ring.sv
// ----------------------------------------------------------------------------
// Indexed deque buffer ring memory
// Single-port synchronous RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idb_ring #(
   parameter int DEPTH      = idb_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = idb_pkg::DATA_WIDTH_DEF,
   localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  mem_we,
   input  wire logic                  mem_re,
   input  wire logic [PTR_W-1:0]      mem_addr,
   input  wire logic [DATA_WIDTH-1:0] mem_wdata,
   output logic      [DATA_WIDTH-1:0] mem_rdata
);

   logic [DATA_WIDTH-1:0] store [DEPTH];
   logic [DATA_WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[mem_addr] <= mem_wdata;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rdata_ff <= store[mem_addr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

`default_nettype wire

// File: src/idb_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed deque buffer controller
// Head pointer and count, command decode, status and ring slot address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module idb_ctrl #(
   parameter int DEPTH      = idb_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = idb_pkg::DATA_WIDTH_DEF,
   localparam int PTR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire idb_pkg::req_type      req,
   output logic                       mem_we,
   output logic                       mem_re,
   output logic      [PTR_W-1:0]      mem_addr,
   output logic      [DATA_WIDTH-1:0] mem_wdata,
   output idb_pkg::rsp_ctl_type       ctl
);

   import idb_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [PTR_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;
   rsp_ctl_type      ctl_ff, ctl_in;

   logic             empty, full, in_range;
   logic [CNT_W-1:0] offset;
   logic [SUM_W-1:0] slot_sum;
   logic [PTR_W-1:0] slot;
   logic [PTR_W-1:0] head_dec, head_inc;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign in_range = (CMP_W'(req.position) < CMP_W'(count_ff));

   // Neighbor slots of the head, wrapping at the ring ends
   assign head_dec = (head_ff == '0) ? PTR_W'(DEPTH - 1) : head_ff - 1'b1;
   assign head_inc = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;

   // Slot of a logical offset from the head: one add, one conditional subtract
   always_comb begin
      case (req.command)
         CMD_PUSH_BACK: offset = count_ff;
         CMD_POP_BACK:  offset = count_ff - 1'b1;
         CMD_READ,
         CMD_WRITE:     offset = CNT_W'(req.position);
         default:       offset = '0;
      endcase
      slot_sum = SUM_W'(head_ff) + SUM_W'(offset);
      if (slot_sum >= SUM_W'(DEPTH)) begin
         slot_sum = slot_sum - SUM_W'(DEPTH);
      end
      slot = PTR_W'(slot_sum);
   end

   // Command decode and next state
   always_comb begin
      head_in   = head_ff;
      count_in  = count_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_addr  = slot;
      mem_wdata = DATA_WIDTH'(req.item);
      ctl_in    = '0;

      if (accept) begin
         ctl_in.valid  = 1'b1;
         ctl_in.status = ST_OK;
         case (req.command)
            CMD_PUSH_FRONT: begin
               if (full) begin
                  ctl_in.status = ST_FULL;
               end else begin
                  head_in  = head_dec;
                  mem_addr = head_dec;
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_PUSH_BACK: begin
               if (full) begin
                  ctl_in.status = ST_FULL;
               end else begin
                  mem_we   = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            CMD_POP_FRONT: begin
               if (empty) begin
                  ctl_in.status = ST_EMPTY;
               end else begin
                  mem_addr        = head_ff;
                  mem_re          = 1'b1;
                  ctl_in.use_data = 1'b1;
                  head_in         = head_inc;
                  count_in        = count_ff - 1'b1;
               end
            end
            CMD_POP_BACK: begin
               if (empty) begin
                  ctl_in.status = ST_EMPTY;
               end else begin
                  mem_re          = 1'b1;
                  ctl_in.use_data = 1'b1;
                  count_in        = count_ff - 1'b1;
               end
            end
            CMD_READ, CMD_WRITE: begin
               if (empty) begin
                  ctl_in.status = ST_EMPTY;
               end else if (!in_range) begin
                  ctl_in.status = ST_RANGE;
               end else if (req.command == CMD_READ) begin
                  mem_re          = 1'b1;
                  ctl_in.use_data = 1'b1;
               end else begin
                  mem_we = 1'b1;
               end
            end
            default: begin
               // unused codes leave head, count and ring as is
            end
         endcase
         ctl_in.occupancy = OCC_W'(count_in);
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
         ctl_ff   <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         ctl_ff   <= ctl_in;
      end
   end

   assign ctl = ctl_ff;

`include "indexed_deque_buffer_assert.svh"

   `IDB_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH), "count past depth")
   `IDB_ASSERT_IMPLY(a_one_access, clock, reset, 1'b1, !(mem_we && mem_re), "read and write together")
   `IDB_ASSERT_NEXT(a_rsp_follows, clock, reset, accept, ctl_ff.valid, "request without response")
   `IDB_ASSERT_NEXT(a_push_grows, clock, reset, mem_we && !(req.command == CMD_WRITE), count_ff == $past(count_ff) + 1'b1, "push did not grow count")
   `IDB_ASSERT_IMPLY(a_data_ok, clock, reset, ctl_ff.use_data, ctl_ff.status == ST_OK, "data on failed request")

endmodule

`default_nettype wire

// File: src/indexed_deque_buffer.sv
// ----------------------------------------------------------------------------
// Indexed deque buffer
// Double-ended queue in one ring memory with indexed read and write.
// ----------------------------------------------------------------------------
// Takes one request per clock: busy never rises, so every start is accepted.
// The response appears on the rsp_ ports in the cycle after the request
// is accepted, marked by rsp_valid for that single cycle; it waits on the
// registered read of the ring memory, whose single port serves one read or one
// write per request. The receiver cannot stall and must take every response
// in the cycle it is shown. No clearing pass follows reset; the ring contents
// are only read inside the held range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_deque_buffer #(
   parameter int DEPTH      = idb_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = idb_pkg::DATA_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire idb_pkg::req_type req,
   output logic                  rsp_valid,
   output idb_pkg::rsp_type      rsp
);

   import idb_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic                  accept;
   logic                  mem_we, mem_re;
   logic [PTR_W-1:0]      mem_addr;
   logic [DATA_WIDTH-1:0] mem_wdata, mem_rdata;
   rsp_ctl_type           ctl;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   idb_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .ctl       (ctl)
   );

   idb_ring #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ring (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_re    (mem_re),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata)
   );

   // Response: memory data only for successful pops and reads
   assign rsp_valid     = ctl.valid;
   assign rsp.item_out  = ctl.use_data ? ITEM_W'(mem_rdata) : '0;
   assign rsp.status    = ctl.status;
   assign rsp.occupancy = ctl.occupancy;

endmodule

`default_nettype wire

// File: tb/idb_deque_checker.sv
// ----------------------------------------------------------------------------
// Indexed deque buffer checker
// Watches the request and response channels of the deque buffer. Keeps its
// own ring, head and fill count, predicts one response per accepted request
// and compares each response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module idb_deque_checker
   import idb_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    busy,
   input  wire req_type req,
   input  wire logic    rsp_valid,
   input  wire rsp_type rsp,
   output int           n_pending,
   output int           n_errors
);

   localparam int DEPTH  = DEPTH_DEF;
   localparam int ADDR_W = $clog2(DEPTH);

   // Shadow of the deque contents
   logic [ITEM_W-1:0] ring [DEPTH];
   logic [ADDR_W-1:0] head;
   logic [OCC_W-1:0]  fill;

   // Predicted responses, oldest first
   rsp_type           exp_rsp [$];
   rsp_type           want;
   int                err_cnt;

   // Report one field mismatch, returns 1 when the field is wrong
   function automatic int field_bad(input string name, input logic [31:0] exp_val,
                                    input logic [31:0] act_val);
      if (act_val !== exp_val) begin
         $display("%0t: %s expected %h actual %h", $time, name, exp_val, act_val);
         return 1;
      end
      return 0;
   endfunction

   // Apply one request to the shadow deque and queue its response
   task automatic predict_deque(input req_type r);
      rsp_type           res;
      logic [ADDR_W-1:0] slot;
      res = '0;
      case (r.command)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (fill == OCC_W'(DEPTH)) begin
               res.status = ST_FULL;
            end else if (r.command == CMD_PUSH_FRONT) begin
               head       = head - 1'b1;
               ring[head] = r.item;
               fill       = fill + 1'b1;
            end else begin
               slot       = head + fill[ADDR_W-1:0];
               ring[slot] = r.item;
               fill       = fill + 1'b1;
            end
         end
         CMD_POP_FRONT: begin
            if (fill == '0) begin
               res.status = ST_EMPTY;
            end else begin
               res.item_out = ring[head];
               head         = head + 1'b1;
               fill         = fill - 1'b1;
            end
         end
         CMD_POP_BACK: begin
            if (fill == '0) begin
               res.status = ST_EMPTY;
            end else begin
               slot         = head + ADDR_W'(fill - 1'b1);
               res.item_out = ring[slot];
               fill         = fill - 1'b1;
            end
         end
         CMD_READ, CMD_WRITE: begin
            if (fill == '0) begin
               res.status = ST_EMPTY;
            end else if (r.position >= fill) begin
               res.status = ST_RANGE;
            end else begin
               slot = head + r.position[ADDR_W-1:0];
               if (r.command == CMD_READ)
                  res.item_out = ring[slot];
               else
                  ring[slot] = r.item;
            end
         end
         // spare codes change nothing
         default: ;
      endcase
      res.occupancy = fill;
      exp_rsp.push_back(res);
   endtask

   // Compare the response shown this cycle, then record the new request
   always @(posedge clock) begin
      if (reset) begin
         head = '0;
         fill = '0;
         exp_rsp.delete();
      end else begin
         if (rsp_valid) begin
            if (exp_rsp.size() == 0) begin
               err_cnt++;
               $display("%0t: unexpected response, expected none, actual %h %0d %0d",
                        $time, rsp.item_out, rsp.status, rsp.occupancy);
            end else begin
               want = exp_rsp.pop_front();
               err_cnt += field_bad("item_out", want.item_out, rsp.item_out);
               err_cnt += field_bad("status", 32'(want.status), 32'(rsp.status));
               err_cnt += field_bad("occupancy", 32'(want.occupancy), 32'(rsp.occupancy));
            end
         end
         if (start && !busy)
            predict_deque(req);
      end
      n_pending <= exp_rsp.size();
      n_errors  <= err_cnt;
   end

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Indexed deque buffer testbench
// Drives directed corner requests, then a long random run that fills the
// deque to capacity, hovers at full and then shrinks it, under several
// sender idle patterns. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
   import idb_pkg::*;

   localparam int DEPTH  = DEPTH_DEF;
   localparam int N_RAND = 1450;

   // Command codes the block ignores
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req;
   logic    rsp_valid;
   rsp_type rsp;
   int      n_pending;
   int      n_errors;

   // Stimulus steering
   int      idle_pct;
   int      held;

   indexed_deque_buffer dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   idb_deque_checker checker_i (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .n_pending (n_pending),
      .n_errors  (n_errors)
   );

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Run limit
   initial begin
      #5_000_000;
      $display("indexed_deque_buffer: mismatch");
      $finish;
   end

   // Send one request, idling first as the current phase asks
   task automatic issue(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                        input logic [ITEM_W-1:0] val);
      req_type r;
      r.command  = cmd;
      r.position = pos;
      r.item     = val;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req   <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      // track the fill level for steering only
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: if (held < DEPTH) held++;
         CMD_POP_FRONT, CMD_POP_BACK:   if (held > 0) held--;
         default: ;
      endcase
   endtask

   // Hold requests off until every response has come back
   task automatic drain_responses();
      start <= 1'b0;
      @(posedge clock);
      while (n_pending != 0) @(posedge clock);
   endtask

   // Stimulus
   initial begin
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      int               n;
      int               pick;
      int               p_push;
      int               p_pop;
      int               p_rw;
      int               hover_left;
      int               phase;
      bit               reached_full;

      reset    = 1'b1;
      start    = 1'b0;
      req      = '0;
      idle_pct = 0;
      held     = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty cases, spare codes, field extremes, range errors
      issue(CMD_POP_FRONT, 12'd0, 32'h0);
      issue(CMD_POP_BACK, 12'd0, 32'h0);
      issue(CMD_READ, 12'd0, 32'h0);
      issue(CMD_WRITE, 12'hFFF, 32'hFFFF_FFFF);
      issue(CMD_SPARE_A, 12'hFFF, 32'hFFFF_FFFF);
      issue(CMD_SPARE_B, 12'd0, 32'h0);
      issue(CMD_PUSH_BACK, 12'd0, 32'hFFFF_FFFF);
      issue(CMD_PUSH_FRONT, 12'hFFF, 32'h0000_0000);
      issue(CMD_PUSH_BACK, 12'd0, 32'hA5A5_A5A5);
      issue(CMD_PUSH_FRONT, 12'd0, 32'h5A5A_5A5A);
      issue(CMD_READ, 12'd0, 32'h0);
      issue(CMD_READ, 12'd3, 32'h0);
      issue(CMD_READ, 12'd4, 32'h0);
      issue(CMD_READ, 12'hFFF, 32'h0);
      issue(CMD_WRITE, 12'd2, 32'hDEAD_BEEF);
      issue(CMD_READ, 12'd2, 32'h0);
      issue(CMD_WRITE, 12'd4, 32'h1234_5678);
      issue(CMD_SPARE_B, 12'd1, 32'h0);
      issue(CMD_POP_FRONT, 12'd0, 32'h0);
      issue(CMD_POP_BACK, 12'd0, 32'h0);
      issue(CMD_POP_FRONT, 12'd0, 32'h0);
      issue(CMD_POP_BACK, 12'd0, 32'h0);
      issue(CMD_POP_FRONT, 12'd0, 32'h0);

      // Let the pipe run dry once before the random part
      drain_responses();

      // Random: grow to full, hover there, then shrink
      reached_full = 1'b0;
      hover_left   = 60;
      for (n = 0; n < N_RAND || hover_left > 0; n++) begin
         phase = (n * 4) / N_RAND;
         case (phase)
            0:       idle_pct = 0;
            1:       idle_pct = 85;
            2:       idle_pct = 0;
            default: idle_pct = 33;
         endcase

         if (!reached_full) begin
            p_push = 88; p_pop = 92; p_rw = 98;
         end else if (hover_left > 0) begin
            p_push = 40; p_pop = 65; p_rw = 95;
         end else begin
            p_push = 15; p_pop = 70; p_rw = 97;
         end

         pick = $urandom_range(99);
         if (pick < p_push)
            cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
         else if (pick < p_pop)
            cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
         else if (pick < p_rw)
            cmd = $urandom_range(1) ? CMD_READ : CMD_WRITE;
         else
            cmd = $urandom_range(1) ? CMD_SPARE_A : CMD_SPARE_B;

         // mostly valid indexes, some at the boundary, some anywhere
         if (held == 0 || $urandom_range(9) == 0)
            pos = POS_W'($urandom_range(4095));
         else if ($urandom_range(19) == 0)
            pos = POS_W'(held);
         else
            pos = POS_W'($urandom_range(held - 1));

         issue(cmd, pos, $urandom);

         if (held == DEPTH)
            reached_full = 1'b1;
         if (reached_full && hover_left > 0)
            hover_left--;
      end

      // Wait out the last responses
      drain_responses();
      repeat (4) @(posedge clock);
      if (n_errors == 0)
         $display("indexed_deque_buffer: match");
      else
         $display("indexed_deque_buffer: mismatch");
      $finish;
   end

endmodule
